[src/sidmh_pkg.sv]
// ----------------------------------------------------------------------------
// sidmh_pkg - string ID multiply hash package
// Constants, types and the product fold functions for the hash core.
// ----------------------------------------------------------------------------
package sidmh_pkg;

  localparam int unsigned MAX_WORDS = 64;
  localparam int unsigned WCNT_W    = $clog2(MAX_WORDS + 1);

  localparam logic [31:0] PAD_WORD_A = 32'h9BE7_4448;
  localparam logic [31:0] PAD_WORD_B = 32'h66F4_2C48;
  localparam logic [31:0] KEY_RESET  = 32'hF4FA_8928;
  localparam logic [31:0] X_RESET    = 32'h37A8_470E;
  localparam logic [31:0] Y_RESET    = 32'h7758_B42B;
  localparam logic [31:0] ROUND_BASE = 32'h267B_0B11;
  localparam logic [31:0] X_OR_MASK  = 32'h0204_0801;
  localparam logic [31:0] X_AND_MASK = 32'hBFEF_7FDF;
  localparam logic [31:0] Y_OR_MASK  = 32'h0080_4021;
  localparam logic [31:0] Y_AND_MASK = 32'h7DFE_FBFF;

  typedef logic [WCNT_W-1:0] wcnt_t;

  // lo + hi + (hi != 0), end-around carry added back in
  function automatic logic [31:0] fold_x(input logic [63:0] prod);
    logic [32:0] wide;
    wide = {1'b0, prod[31:0]} + {1'b0, prod[63:32]} + {32'd0, (prod[63:32] != 32'd0)};
    return wide[31:0] + {31'd0, wide[32]};
  endfunction

  // lo + 2*hi + hi[31], plus 2 on carry out
  function automatic logic [31:0] fold_y(input logic [63:0] prod);
    logic [32:0] wide;
    wide = {1'b0, prod[31:0]} + {1'b0, prod[62:32], 1'b0} + {32'd0, prod[63]};
    return wide[31:0] + (wide[32] ? 32'd2 : 32'd0);
  endfunction

endpackage

[src/string_id_multiply_hash_top.sv]
// ----------------------------------------------------------------------------
// string_id_multiply_hash_top - name word hash to 32-bit ID
// Iterative two-accumulator multiply hash on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  payload                      marker
//  s_*       in         tdata[31:0] name_word        tlast = last word of name
//  m_*       out        tdata[31:0] id               -
//
//  Each round steps through prepare, multiply x, multiply y and fold y on one shared multiplier.
//  A hashed word holds s_tready low until its round is done; a skipped word starts no round
//  and leaves s_tready high; a last word adds two padding rounds before the ID is registered
//  on m_tdata.
//  rst is synchronous; s_tready is low while a round is in flight.
//  A finished ID waiting on m_tready holds the last fold until it is taken.
// ----------------------------------------------------------------------------
module string_id_multiply_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] name_word
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] id
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL_X, S_MUL_Y, S_FOLD_Y} state_t;
  typedef enum logic [1:0] {PH_WORD, PH_PAD_A, PH_PAD_B} phase_t;

  state_t            state;
  phase_t            phase;
  logic [31:0]       acc_x;
  logic [31:0]       acc_y;
  logic [31:0]       rot_key;
  logic [31:0]       word_r;
  logic [31:0]       mx_r;
  logic [31:0]       my_r;
  logic [63:0]       prod;
  logic              last_r;
  logic              stopped;
  sidmh_pkg::wcnt_t  words_taken;

  logic [31:0] round_word;
  logic [31:0] key_rot;
  logic [31:0] rk;
  logic [31:0] ax;
  logic [31:0] ay;
  logic [31:0] mx;
  logic [31:0] my;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] y_fold;
  logic        accept;
  logic        eligible;
  logic        out_block;
  logic        id_load;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign eligible  = !stopped &&
                     (words_taken < sidmh_pkg::WCNT_W'(sidmh_pkg::MAX_WORDS));
  assign out_block = m_tvalid && !m_tready;
  assign id_load   = (state == S_FOLD_Y) && (phase == PH_PAD_B) && !out_block;

  always_comb begin
    unique case (phase)
      PH_WORD:  round_word = word_r;
      PH_PAD_A: round_word = sidmh_pkg::PAD_WORD_A;
      PH_PAD_B: round_word = sidmh_pkg::PAD_WORD_B;
      default:  round_word = word_r;
    endcase
  end

  assign key_rot = {rot_key[30:0], rot_key[31]};
  assign rk      = sidmh_pkg::ROUND_BASE ^ key_rot;
  assign ax      = acc_x ^ round_word;
  assign ay      = acc_y ^ round_word;
  assign mx      = ((rk + ay) | sidmh_pkg::X_OR_MASK) & sidmh_pkg::X_AND_MASK;
  assign my      = ((rk + ax) | sidmh_pkg::Y_OR_MASK) & sidmh_pkg::Y_AND_MASK;

  // shared multiplier operands
  assign mul_a  = (state == S_MUL_X) ? acc_x : acc_y;
  assign mul_b  = (state == S_MUL_X) ? mx_r : my_r;
  assign y_fold = sidmh_pkg::fold_y(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_WORD;
      acc_x       <= sidmh_pkg::X_RESET;
      acc_y       <= sidmh_pkg::Y_RESET;
      rot_key     <= sidmh_pkg::KEY_RESET;
      stopped     <= 1'b0;
      words_taken <= '0;
      last_r      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (id_load) begin
        m_tdata  <= acc_x ^ y_fold;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            word_r <= s_tdata;
            last_r <= s_tlast;
            if (eligible && s_tdata != 32'd0) begin
              phase <= PH_WORD;
              state <= S_PREP;
            end else if (s_tlast) begin
              phase <= PH_PAD_A;
              state <= S_PREP;
            end
            if (s_tlast) begin
              stopped     <= 1'b0;
              words_taken <= '0;
            end else if (eligible && s_tdata == 32'd0) begin
              stopped <= 1'b1;
            end else if (eligible) begin
              words_taken <= words_taken + 1'b1;
            end
          end
        end
        S_PREP: begin
          rot_key <= key_rot;
          acc_x   <= ax;
          acc_y   <= ay;
          mx_r    <= mx;
          my_r    <= my;
          state   <= S_MUL_X;
        end
        S_MUL_X: begin
          prod  <= {32'd0, mul_a} * {32'd0, mul_b};
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          acc_x <= sidmh_pkg::fold_x(prod);
          prod  <= {32'd0, mul_a} * {32'd0, mul_b};
          state <= S_FOLD_Y;
        end
        S_FOLD_Y: begin
          unique case (phase)
            PH_WORD: begin
              acc_y <= y_fold;
              if (last_r) begin
                phase <= PH_PAD_A;
                state <= S_PREP;
              end else begin
                state <= S_IDLE;
              end
            end
            PH_PAD_A: begin
              acc_y <= y_fold;
              phase <= PH_PAD_B;
              state <= S_PREP;
            end
            PH_PAD_B: begin
              // hold until the previous ID has been taken
              if (!out_block) begin
                acc_x    <= sidmh_pkg::X_RESET;
                acc_y    <= sidmh_pkg::Y_RESET;
                rot_key  <= sidmh_pkg::KEY_RESET;
                phase    <= PH_WORD;
                state    <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/sidmh_checker.sv]
// ----------------------------------------------------------------------------
// sidmh_checker - port-level checks for the string ID hash
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module sidmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // stalled ID holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("ID changed or dropped while stalled");

  // a last word always starts the padding rounds
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after last word");

  // an ID appears only at the end of a round, never while idle
  a_out_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("ID raised without a round in flight");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("ID valid after reset");

endmodule

bind string_id_multiply_hash_top sidmh_checker u_sidmh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
